// File: rtl/core/assert_macros.svh
// assertion macros shared by the scaler rtl
// no dependencies; set NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define BIS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scaler assertion failed");
// condition must never be seen at a clock edge out of reset
`define BIS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("scaler forbidden condition seen");
`else
`define BIS_ASSERT(lbl, clk, rst_n, prop)
`define BIS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/bis_pkg.sv
// shared types, constants and mix functions of the bilinear scaler
// no dependencies
package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 8;
  localparam int FRAC_ONE       = 1 << FRAC_BITS;

  localparam int COORD_W    = 12;
  localparam int SRC_SIZE_W = 9;
  localparam int DST_SIZE_W = 13;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;

  localparam int COL_W   = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W   = $clog2(MAX_SRC_HEIGHT);
  localparam int IDX_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int PROD_W  = COORD_W + IDX_W;
  localparam int NUM_W   = PROD_W + FRAC_BITS;
  localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W = 3'd0,
    CFG_SRC_H = 3'd1,
    CFG_DST_W = 3'd2,
    CFG_DST_H = 3'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // effective sizes after clamping
  typedef struct packed {
    logic [SRC_SIZE_W-1:0] sw;
    logic [SRC_SIZE_W-1:0] sh;
    logic [DST_SIZE_W-1:0] dw;
    logic [DST_SIZE_W-1:0] dh;
  } cfg_t;

  typedef struct packed {
    logic               vld;
    logic               sample;
    logic               direct;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pixel_t             pix;
  } item_t;

  typedef struct packed {
    logic                 vld;
    logic                 sample;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    pixel_t               pix;
    logic [COL_W-1:0]     x0;
    logic [COL_W-1:0]     x1;
    logic [ROW_W-1:0]     y0;
    logic [ROW_W-1:0]     y1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } addr_t;

  typedef struct packed {
    logic                 vld;
    pixel_t               a;
    pixel_t               b;
    pixel_t               c;
    pixel_t               d;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } quad_t;

  // floor((a*(one-f) + b*f) / one) on one channel
  function automatic logic [CH_W-1:0] mix_ch(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0]        wa;
    logic [CH_W+FRAC_BITS:0]   pa;
    logic [CH_W+FRAC_BITS:0]   pb;
    logic [CH_W+FRAC_BITS:0]   s;
    wa = (FRAC_BITS+1)'(FRAC_ONE) - {1'b0, f};
    pa = a * wa;
    pb = b * f;
    s  = pa + pb;
    return s[FRAC_BITS+CH_W-1:FRAC_BITS];
  endfunction

  function automatic pixel_t mix_px(input pixel_t a, input pixel_t b,
                                    input logic [FRAC_BITS-1:0] f);
    pixel_t r;
    r.red   = mix_ch(a.red,   b.red,   f);
    r.green = mix_ch(a.green, b.green, f);
    r.blue  = mix_ch(a.blue,  b.blue,  f);
    r.alpha = mix_ch(a.alpha, b.alpha, f);
    return r;
  endfunction

endpackage

// File: rtl/core/bis_coord.sv
// source position pipeline: multiply, one-bit-per-stage divide, clamp
// depends on bis_pkg
module bis_coord import bis_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cfg_t  cfg,
  input  item_t in_item,
  output addr_t addr_o
);

  item_t                 item_r [0:NUM_W];
  logic [NUM_W-1:0]      nx_r   [0:NUM_W];
  logic [NUM_W-1:0]      ny_r   [0:NUM_W];
  logic [NUM_W-1:0]      qx_r   [0:NUM_W];
  logic [NUM_W-1:0]      qy_r   [0:NUM_W];
  logic [DST_SIZE_W-1:0] rx_r   [0:NUM_W];
  logic [DST_SIZE_W-1:0] ry_r   [0:NUM_W];

  logic [COL_W-1:0]  swm1;
  logic [ROW_W-1:0]  shm1;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  addr_t             addr_r;
  addr_t             addr_nxt;

  assign swm1 = COL_W'(cfg.sw - 1'b1);
  assign shm1 = ROW_W'(cfg.sh - 1'b1);

  // numerator coord*(size-1)
  assign prod_x = in_item.x * swm1;
  assign prod_y = in_item.y * shm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r[0].vld <= 1'b0;
    end else if (en) begin
      item_r[0] <= in_item;
      nx_r[0]   <= {prod_x, {FRAC_BITS{1'b0}}};
      ny_r[0]   <= {prod_y, {FRAC_BITS{1'b0}}};
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      rx_r[0]   <= '0;
      ry_r[0]   <= '0;
    end
  end

  // restoring divide by the destination size, one quotient bit a stage
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [DST_SIZE_W:0] tx;
    logic [DST_SIZE_W:0] ty;
    logic                gx;
    logic                gy;

    always_comb begin
      tx = {rx_r[k], nx_r[k][NUM_W-1]};
      ty = {ry_r[k], ny_r[k][NUM_W-1]};
      gx = (tx >= {1'b0, cfg.dw});
      gy = (ty >= {1'b0, cfg.dh});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        item_r[k+1].vld <= 1'b0;
      end else if (en) begin
        item_r[k+1] <= item_r[k];
        nx_r[k+1]   <= nx_r[k] << 1;
        ny_r[k+1]   <= ny_r[k] << 1;
        qx_r[k+1]   <= {qx_r[k][NUM_W-2:0], gx};
        qy_r[k+1]   <= {qy_r[k][NUM_W-2:0], gy};
        rx_r[k+1]   <= gx ? DST_SIZE_W'(tx - {1'b0, cfg.dw}) : tx[DST_SIZE_W-1:0];
        ry_r[k+1]   <= gy ? DST_SIZE_W'(ty - {1'b0, cfg.dh}) : ty[DST_SIZE_W-1:0];
      end
    end
  end

  // neighbor indexes and fractions, clamped to the last column and row
  always_comb begin
    addr_nxt        = '0;
    addr_nxt.vld    = item_r[NUM_W].vld;
    addr_nxt.sample = item_r[NUM_W].sample;
    addr_nxt.x      = item_r[NUM_W].x;
    addr_nxt.y      = item_r[NUM_W].y;
    addr_nxt.pix    = item_r[NUM_W].pix;
    if (item_r[NUM_W].direct) begin
      addr_nxt.x0 = (item_r[NUM_W].x >= COORD_W'(swm1)) ? swm1
                                                        : COL_W'(item_r[NUM_W].x);
      addr_nxt.y0 = (item_r[NUM_W].y >= COORD_W'(shm1)) ? shm1
                                                        : ROW_W'(item_r[NUM_W].y);
      addr_nxt.fx = '0;
      addr_nxt.fy = '0;
    end else begin
      addr_nxt.x0 = (qx_r[NUM_W][NUM_W-1:FRAC_BITS] >= PROD_W'(swm1)) ? swm1
                    : COL_W'(qx_r[NUM_W][NUM_W-1:FRAC_BITS]);
      addr_nxt.y0 = (qy_r[NUM_W][NUM_W-1:FRAC_BITS] >= PROD_W'(shm1)) ? shm1
                    : ROW_W'(qy_r[NUM_W][NUM_W-1:FRAC_BITS]);
      addr_nxt.fx = qx_r[NUM_W][FRAC_BITS-1:0];
      addr_nxt.fy = qy_r[NUM_W][FRAC_BITS-1:0];
    end
    addr_nxt.x1 = (addr_nxt.x0 == swm1) ? addr_nxt.x0 : addr_nxt.x0 + 1'b1;
    addr_nxt.y1 = (addr_nxt.y0 == shm1) ? addr_nxt.y0 : addr_nxt.y0 + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r.vld <= 1'b0;
    end else if (en) begin
      addr_r <= addr_nxt;
    end
  end

  assign addr_o = addr_r;

endmodule

// File: rtl/core/bis_store.sv
// source image store: four banks split by column and row parity
// depends on bis_pkg
module bis_store import bis_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  addr_t addr_i,
  output quad_t quad_o
);

  localparam int BANK_DEPTH = 1 << BANK_AW;

  pixel_t             bank_q [0:1][0:1];
  logic               we;
  logic [BANK_AW-1:0] waddr;
  logic               vld_r;
  logic               x0p_r;
  logic               x1p_r;
  logic               y0p_r;
  logic               y1p_r;
  logic [FRAC_BITS-1:0] fx_r;
  logic [FRAC_BITS-1:0] fy_r;

  // loads outside the store are dropped
  assign we = addr_i.vld && !addr_i.sample &&
              ({1'b0, addr_i.x} < (COORD_W+1)'(MAX_SRC_WIDTH)) &&
              ({1'b0, addr_i.y} < (COORD_W+1)'(MAX_SRC_HEIGHT));
  assign waddr = {addr_i.y[ROW_W-1:1], addr_i.x[COL_W-1:1]};

  // a load and a sample never sit in this stage together; the banks read on
  // a load as well, but that read result is not marked valid
  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar c = 0; c < 2; c++) begin : g_col
      pixel_t             mem [0:BANK_DEPTH-1];
      pixel_t             rd_r;
      logic [ROW_W-1:0]   rrow;
      logic [COL_W-1:0]   rcol;
      logic [BANK_AW-1:0] raddr;

      assign rrow  = (addr_i.y0[0] == 1'(r)) ? addr_i.y0 : addr_i.y1;
      assign rcol  = (addr_i.x0[0] == 1'(c)) ? addr_i.x0 : addr_i.x1;
      assign raddr = {rrow[ROW_W-1:1], rcol[COL_W-1:1]};

      always_ff @(posedge clk) begin
        if (en && we && (addr_i.y[0] == 1'(r)) && (addr_i.x[0] == 1'(c))) begin
          mem[waddr] <= addr_i.pix;
        end
        if (en) begin
          rd_r <= mem[raddr];
        end
      end

      assign bank_q[r][c] = rd_r;
    end
  end

  // bank select and fractions travel with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= addr_i.vld && addr_i.sample;
      x0p_r <= addr_i.x0[0];
      x1p_r <= addr_i.x1[0];
      y0p_r <= addr_i.y0[0];
      y1p_r <= addr_i.y1[0];
      fx_r  <= addr_i.fx;
      fy_r  <= addr_i.fy;
    end
  end

  always_comb begin
    quad_o.vld = vld_r;
    quad_o.a   = bank_q[y0p_r][x0p_r];
    quad_o.b   = bank_q[y0p_r][x1p_r];
    quad_o.c   = bank_q[y1p_r][x0p_r];
    quad_o.d   = bank_q[y1p_r][x1p_r];
    quad_o.fx  = fx_r;
    quad_o.fy  = fy_r;
  end

endmodule

// File: rtl/core/bis_mix.sv
// two-stage bilinear mix: horizontal pair, then vertical, into the output register
// depends on bis_pkg
module bis_mix import bis_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  quad_t  quad_i,
  output logic   out_vld,
  output pixel_t out_pix
);

  pixel_t               ab_r;
  pixel_t               cd_r;
  logic [FRAC_BITS-1:0] fy_r;
  logic                 vld_h_r;
  pixel_t               pix_r;
  logic                 vld_r;

  // horizontal mix of both rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_h_r <= 1'b0;
    end else if (en) begin
      vld_h_r <= quad_i.vld;
      ab_r    <= mix_px(quad_i.a, quad_i.b, quad_i.fx);
      cd_r    <= mix_px(quad_i.c, quad_i.d, quad_i.fx);
      fy_r    <= quad_i.fy;
    end
  end

  // vertical mix into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_h_r;
      pix_r <= mix_px(ab_r, cd_r, fy_r);
    end
  end

  assign out_vld = vld_r;
  assign out_pix = pix_r;

endmodule

// File: rtl/core/bilinear_image_scaler.sv
// bilinear image scaler top: config registers, pipeline control, assertions
// depends on bis_pkg, bis_coord, bis_store, bis_mix, assert_macros.svh
//
//   channel | direction | handshake          | carries
//   in_     | input     | in_valid/in_stall  | operation, coordinates, pixel
//   out_    | output    | out_valid/out_stall| scaled pixel
//   cfg_    | input     | cfg_valid/cfg_ready| register index and data
//
// one transaction per cycle in while in_stall is low; a sample passes the input register,
// the one-bit-per-stage divider, the address register, the bank read and the horizontal and vertical mix
// registers; the pipeline freezes only while a result waits at a stalled output
// no clearing pass: the image store is undefined until loaded
// config registers reset to 256; cfg_ready is always high
`include "assert_macros.svh"
module bilinear_image_scaler import bis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [CH_W-1:0]       out_alpha,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DST_SIZE_W-1:0] cfg_data
);

  logic [SRC_SIZE_W-1:0] src_w_r;
  logic [SRC_SIZE_W-1:0] src_h_r;
  logic [DST_SIZE_W-1:0] dst_w_r;
  logic [DST_SIZE_W-1:0] dst_h_r;
  cfg_t   cfg;
  logic   en;
  item_t  in_item;
  addr_t  addr_q;
  quad_t  quad_q;
  pixel_t out_pix;
  logic   out_vld;

  // config register writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_SIZE_W'(256);
      src_h_r <= SRC_SIZE_W'(256);
      dst_w_r <= DST_SIZE_W'(256);
      dst_h_r <= DST_SIZE_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SRC_W: src_w_r <= cfg_data[SRC_SIZE_W-1:0];
        CFG_SRC_H: src_h_r <= cfg_data[SRC_SIZE_W-1:0];
        CFG_DST_W: dst_w_r <= cfg_data;
        CFG_DST_H: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, source capped at the store size
  always_comb begin
    if (src_w_r == '0)                      cfg.sw = SRC_SIZE_W'(1);
    else if (int'(src_w_r) > MAX_SRC_WIDTH) cfg.sw = SRC_SIZE_W'(MAX_SRC_WIDTH);
    else                                    cfg.sw = src_w_r;
    if (src_h_r == '0)                       cfg.sh = SRC_SIZE_W'(1);
    else if (int'(src_h_r) > MAX_SRC_HEIGHT) cfg.sh = SRC_SIZE_W'(MAX_SRC_HEIGHT);
    else                                     cfg.sh = src_h_r;
    cfg.dw = (dst_w_r == '0) ? DST_SIZE_W'(1) : dst_w_r;
    cfg.dh = (dst_h_r == '0) ? DST_SIZE_W'(1) : dst_h_r;
  end

  // pipeline advances unless a result waits at a stalled output
  assign en       = !(out_vld && out_stall);
  assign in_stall = !en;

  always_comb begin
    in_item.vld    = in_valid && en;
    in_item.sample = (in_operation == OP_SAMPLE);
    in_item.direct = (DST_SIZE_W'(cfg.sw) == cfg.dw) && (DST_SIZE_W'(cfg.sh) == cfg.dh);
    in_item.x      = in_coord_x;
    in_item.y      = in_coord_y;
    in_item.pix.red   = in_red;
    in_item.pix.green = in_green;
    in_item.pix.blue  = in_blue;
    in_item.pix.alpha = in_alpha;
  end

  bis_coord u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg),
    .in_item (in_item),
    .addr_o  (addr_q)
  );

  bis_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .addr_i (addr_q),
    .quad_o (quad_q)
  );

  bis_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .quad_i  (quad_q),
    .out_vld (out_vld),
    .out_pix (out_pix)
  );

  assign out_valid = out_vld;
  assign out_red   = out_pix.red;
  assign out_green = out_pix.green;
  assign out_blue  = out_pix.blue;
  assign out_alpha = out_pix.alpha;

  // right neighbor is the same column or the next one
  `BIS_ASSERT_NEVER(a_col_pair, clk, rst_n, addr_q.vld && addr_q.sample && (addr_q.x1 != addr_q.x0) && (addr_q.x1 != addr_q.x0 + 1'b1))
  // lower neighbor is the same row or the next one
  `BIS_ASSERT_NEVER(a_row_pair, clk, rst_n, addr_q.vld && addr_q.sample && (addr_q.y1 != addr_q.y0) && (addr_q.y1 != addr_q.y0 + 1'b1))
  // a frozen pipeline keeps its memory stage
  `BIS_ASSERT(a_freeze, clk, rst_n, !en |=> $stable(addr_q))

endmodule
